FILE: design/dsp_interface_register_block_unit_assert.svh
// Assertion macros for the DSP interface register block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DSP_INTERFACE_REGISTER_BLOCK_UNIT_ASSERT_SVH
`define DSP_INTERFACE_REGISTER_BLOCK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DIRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dirb check failed");

// Next-cycle implication, disabled while reset is low.
`define DIRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dirb check failed");

`endif

FILE: design/dspirb_pkg.sv
// Package for the DSP interface register block: item types, op codes,
// register offsets and control-register masks. No dependencies.
`default_nettype none
package dspirb_pkg;

    localparam logic [2:0] OP_READ16  = 3'd0;
    localparam logic [2:0] OP_WRITE16 = 3'd1;
    localparam logic [2:0] OP_WRITE32 = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_IRQ     = 3'd4;

    localparam logic [1:0] KIND_DSP   = 2'd0;
    localparam logic [1:0] KIND_AUX   = 2'd1;
    localparam logic [1:0] KIND_AUDIO = 2'd2;

    localparam logic [1:0] MB_NONE = 2'd0;
    localparam logic [1:0] MB_HIGH = 2'd1;
    localparam logic [1:0] MB_LOW  = 2'd2;
    localparam logic [1:0] MB_BOTH = 2'd3;

    localparam logic [15:0] REG_MB_TO_HI   = 16'h5000;
    localparam logic [15:0] REG_MB_TO_LO   = 16'h5002;
    localparam logic [15:0] REG_MB_FROM_HI = 16'h5004;
    localparam logic [15:0] REG_MB_FROM_LO = 16'h5006;
    localparam logic [15:0] REG_CTRL       = 16'h500A;
    localparam logic [15:0] REG_AR_SIZE    = 16'h5012;
    localparam logic [15:0] REG_AR_MODE    = 16'h5016;
    localparam logic [15:0] REG_AR_REFRESH = 16'h501A;
    localparam logic [15:0] REG_MEM_HI     = 16'h5020;
    localparam logic [15:0] REG_MEM_LO     = 16'h5022;
    localparam logic [15:0] REG_AUX_HI     = 16'h5024;
    localparam logic [15:0] REG_AUX_LO     = 16'h5026;
    localparam logic [15:0] REG_CNT_HI     = 16'h5028;
    localparam logic [15:0] REG_CNT_LO     = 16'h502A;
    localparam logic [15:0] REG_AUD_HI     = 16'h5030;
    localparam logic [15:0] REG_AUD_LO     = 16'h5032;
    localparam logic [15:0] REG_AUD_CTRL   = 16'h5036;
    localparam logic [15:0] REG_AUD_LEFT   = 16'h503A;

    localparam logic [15:0] CTRL_CORE_MASK = 16'h0C07;
    localparam logic [15:0] CTRL_COPY_MASK = 16'hFD57;
    localparam logic [15:0] CTRL_PEND_MASK = 16'h00A8;
    localparam logic [15:0] CTRL_RESET     = 16'h0004;
    localparam logic [15:0] FLAG_AUDIO     = 16'h0008;
    localparam logic [15:0] FLAG_AUX       = 16'h0020;
    localparam logic [15:0] FLAG_DSP       = 16'h0080;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 200;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] reg_offset;
        logic [31:0] write_data;
        logic [15:0] core_value;
        logic [1:0]  interrupt_kind;
        logic        interrupt_set;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_line;
        logic [1:0]  mailbox_strobe;
        logic [31:0] mailbox_data;
        logic        audio_send;
        logic [31:0] audio_address;
        logic [17:0] audio_length;
        logic        dma_start;
        logic        dma_direction;
        logic [31:0] dma_mem_address;
        logic [31:0] dma_aux_address;
        logic [30:0] dma_length;
    } t_result;

endpackage
`default_nettype wire

FILE: design/dspirb_in_stage.sv
// Input register of the DSP interface register block: takes a beat and
// unpacks it into an item. Depends on dspirb_pkg.
`default_nettype none
module dspirb_in_stage
    import dspirb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    // tdata: reg_offset, write_data, core_value, interrupt_kind, interrupt_set, pad
    input  wire logic [IN_DATA_W-1:0] i_data,
    // tuser: operation
    input  wire logic [2:0]           i_user,
    input  wire logic                 i_take,
    output logic                      o_valid,
    output t_item                     o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.operation      = i_user;
        n_item.reg_offset     = i_data[15:0];
        n_item.write_data     = i_data[47:16];
        n_item.core_value     = i_data[63:48];
        n_item.interrupt_kind = i_data[65:64];
        n_item.interrupt_set  = i_data[66];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

FILE: design/dspirb_regs.sv
// Register file and per-beat decode of the DSP interface register block.
// Depends on dspirb_pkg and the assertion macro header.
`default_nettype none
`include "dsp_interface_register_block_unit_assert.svh"
module dspirb_regs
    import dspirb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire t_item i_item,
    output t_result    o_res
);

    logic [15:0] r_ctrl,      n_ctrl;
    logic [15:0] r_ar_size,   n_ar_size;
    logic [15:0] r_ar_mode,   n_ar_mode;
    logic [15:0] r_ar_refr,   n_ar_refr;
    logic [31:0] r_mem_addr,  n_mem_addr;
    logic [31:0] r_aux_addr,  n_aux_addr;
    logic [31:0] r_count,     n_count;
    logic [1:0]  r_half,      n_half;
    logic [31:0] r_aud_addr,  n_aud_addr;
    logic [15:0] r_aud_ctrl,  n_aud_ctrl;
    logic [14:0] r_left,      n_left;

    logic [15:0] v16;
    logic [15:0] ctrl_tmp;
    logic [14:0] blocks;
    logic [14:0] left_dec;
    logic        dma_try;
    t_result     res;

    assign v16      = i_item.write_data[15:0];
    assign ctrl_tmp = (v16 & ~CTRL_CORE_MASK) | (i_item.core_value & CTRL_CORE_MASK);
    assign blocks   = r_aud_ctrl[14:0];
    assign left_dec = r_left - 15'd1;

    always_comb begin
        n_ctrl     = r_ctrl;
        n_ar_size  = r_ar_size;
        n_ar_mode  = r_ar_mode;
        n_ar_refr  = r_ar_refr;
        n_mem_addr = r_mem_addr;
        n_aux_addr = r_aux_addr;
        n_count    = r_count;
        n_half     = r_half;
        n_aud_addr = r_aud_addr;
        n_aud_ctrl = r_aud_ctrl;
        n_left     = r_left;
        dma_try    = 1'b0;
        res        = '0;

        case (i_item.operation)
            OP_READ16: begin
                case (i_item.reg_offset)
                    REG_MB_TO_HI, REG_MB_TO_LO,
                    REG_MB_FROM_HI, REG_MB_FROM_LO:
                        res.read_data = i_item.core_value;
                    REG_CTRL: res.read_data = (r_ctrl & ~CTRL_CORE_MASK)
                                            | (i_item.core_value & CTRL_CORE_MASK);
                    REG_AR_SIZE:    res.read_data = r_ar_size;
                    REG_AR_MODE:    res.read_data = r_ar_mode;
                    REG_AR_REFRESH: res.read_data = r_ar_refr;
                    REG_MEM_HI:     res.read_data = r_mem_addr[31:16];
                    REG_MEM_LO:     res.read_data = r_mem_addr[15:0];
                    REG_AUX_HI:     res.read_data = r_aux_addr[31:16];
                    REG_AUX_LO:     res.read_data = r_aux_addr[15:0];
                    REG_CNT_HI:     res.read_data = r_count[31:16];
                    REG_CNT_LO:     res.read_data = r_count[15:0];
                    REG_AUD_HI:     res.read_data = r_aud_addr[31:16];
                    REG_AUD_LO:     res.read_data = r_aud_addr[15:0];
                    REG_AUD_CTRL:   res.read_data = r_aud_ctrl;
                    REG_AUD_LEFT:   res.read_data = {1'b0, r_left};
                    default:        res.read_data = '0;
                endcase
            end
            OP_WRITE16: begin
                case (i_item.reg_offset)
                    REG_MB_TO_HI: begin
                        res.mailbox_strobe = MB_HIGH;
                        res.mailbox_data   = {v16, 16'h0000};
                    end
                    REG_MB_TO_LO: begin
                        res.mailbox_strobe = MB_LOW;
                        res.mailbox_data   = {16'h0000, v16};
                    end
                    REG_CTRL: n_ctrl = (ctrl_tmp & CTRL_COPY_MASK)
                                     | (r_ctrl & CTRL_PEND_MASK & ~ctrl_tmp);
                    REG_AR_SIZE:    n_ar_size = v16;
                    REG_AR_MODE:    n_ar_mode = v16;
                    REG_AR_REFRESH: n_ar_refr = v16;
                    REG_MEM_HI:     n_mem_addr[31:16] = v16;
                    REG_MEM_LO:     n_mem_addr[15:0]  = v16;
                    REG_AUX_HI:     n_aux_addr[31:16] = v16;
                    REG_AUX_LO:     n_aux_addr[15:0]  = v16;
                    REG_CNT_HI: begin
                        n_count[31:16] = v16;
                        n_half         = r_half | 2'b01;
                        dma_try        = 1'b1;
                    end
                    REG_CNT_LO: begin
                        n_count[15:0] = v16;
                        n_half        = r_half | 2'b10;
                        dma_try       = 1'b1;
                    end
                    REG_AUD_HI: n_aud_addr[31:16] = v16;
                    REG_AUD_LO: n_aud_addr[15:0]  = v16;
                    REG_AUD_CTRL: begin
                        n_aud_ctrl = v16;
                        n_left     = v16[14:0];
                    end
                    default: ;
                endcase
            end
            OP_WRITE32: begin
                case (i_item.reg_offset)
                    REG_MB_TO_HI: begin
                        res.mailbox_strobe = MB_BOTH;
                        res.mailbox_data   = i_item.write_data;
                    end
                    REG_AUD_HI: n_aud_addr = i_item.write_data;
                    REG_MEM_HI: n_mem_addr = i_item.write_data;
                    REG_AUX_HI: n_aux_addr = i_item.write_data;
                    REG_CNT_HI: begin
                        n_count = i_item.write_data;
                        n_half  = 2'b11;
                        dma_try = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_aud_ctrl[15] && (r_left != '0)) begin
                    if (r_left == blocks) begin
                        res.audio_send    = 1'b1;
                        res.audio_address = r_aud_addr;
                        res.audio_length  = {blocks, 3'b000};
                    end
                    if (left_dec == '0) begin
                        n_ctrl = r_ctrl | FLAG_AUDIO;
                        n_left = blocks;
                    end else begin
                        n_left = left_dec;
                    end
                end
            end
            OP_IRQ: begin
                case (i_item.interrupt_kind)
                    KIND_DSP:   n_ctrl = i_item.interrupt_set ? (r_ctrl | FLAG_DSP)
                                                              : (r_ctrl & ~FLAG_DSP);
                    KIND_AUX:   n_ctrl = i_item.interrupt_set ? (r_ctrl | FLAG_AUX)
                                                              : (r_ctrl & ~FLAG_AUX);
                    KIND_AUDIO: n_ctrl = i_item.interrupt_set ? (r_ctrl | FLAG_AUDIO)
                                                              : (r_ctrl & ~FLAG_AUDIO);
                    default: ;
                endcase
            end
            default: ;
        endcase

        // both count halves in: fire DMA, keep direction bit only
        if (dma_try && (n_half == 2'b11)) begin
            res.dma_start       = 1'b1;
            res.dma_direction   = n_count[31];
            res.dma_mem_address = n_mem_addr;
            res.dma_aux_address = n_aux_addr;
            res.dma_length      = n_count[30:0];
            n_count             = {n_count[31], 31'd0};
            n_half              = 2'b00;
            n_ctrl              = n_ctrl | FLAG_AUX;
        end

        res.irq_line = (n_ctrl[3] & n_ctrl[4]) | (n_ctrl[5] & n_ctrl[6])
                     | (n_ctrl[7] & n_ctrl[8]);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= CTRL_RESET;
            r_ar_size  <= '0;
            r_ar_mode  <= 16'd1;
            r_ar_refr  <= '0;
            r_mem_addr <= '0;
            r_aux_addr <= '0;
            r_count    <= '0;
            r_half     <= '0;
            r_aud_addr <= '0;
            r_aud_ctrl <= '0;
            r_left     <= '0;
        end else if (i_adv) begin
            r_ctrl     <= n_ctrl;
            r_ar_size  <= n_ar_size;
            r_ar_mode  <= n_ar_mode;
            r_ar_refr  <= n_ar_refr;
            r_mem_addr <= n_mem_addr;
            r_aux_addr <= n_aux_addr;
            r_count    <= n_count;
            r_half     <= n_half;
            r_aud_addr <= n_aud_addr;
            r_aud_ctrl <= n_aud_ctrl;
            r_left     <= n_left;
        end
    end

    `DIRB_ASSERT_NXT(a_dma_clears_halves, i_clk, i_rst_n, i_adv && res.dma_start,
                     r_half == 2'b00 && r_count[30:0] == 31'd0 && r_ctrl[5])
    `DIRB_ASSERT_IMP(a_read_only_on_read, i_clk, i_rst_n, res.read_data != 16'h0000,
                     i_item.operation == OP_READ16)
    `DIRB_ASSERT_IMP(a_send_only_on_tick, i_clk, i_rst_n, res.audio_send,
                     i_item.operation == OP_TICK && r_aud_ctrl[15])
    `DIRB_ASSERT_NXT(a_ctrl_bit9_low, i_clk, i_rst_n, i_adv, !r_ctrl[9])

endmodule
`default_nettype wire

FILE: design/dsp_interface_register_block_unit.sv
// Top level of the DSP interface register block: input register, register
// file with decode, and result register. Depends on dspirb_pkg,
// dspirb_in_stage and dspirb_regs.
// A beat passes through the input register, then the result register, on its way
// to the result beat. Throughput: one beat per cycle while m_axis_tready does not
// stall the output; each beat's register update completes in the cycle it leaves the input register.
// Reset (i_rst_n low, synchronous): both stages empty, control 0x0004,
// aux-RAM mode 1, all other registers 0.
`default_nettype none
module dsp_interface_register_block_unit
    import dspirb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: reg_offset[15:0], write_data[47:16], core_value[63:48],
    //        interrupt_kind[65:64], interrupt_set[66], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[2:0]
    input  wire logic [2:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: read_data[15:0], irq_line[16], mailbox_strobe[18:17],
    //        mailbox_data[50:19], audio_send[51], audio_address[83:52],
    //        audio_length[101:84], dma_start[102], dma_direction[103],
    //        dma_mem_address[135:104], dma_aux_address[167:136],
    //        dma_length[198:168], zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                  in_valid;
    t_item                 in_item;
    t_result               res;
    logic                  out_free;
    logic                  adv;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign out_free = !r_out_valid || m_axis_tready;
    assign adv      = in_valid && out_free;

    dspirb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_take  (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    dspirb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {1'b0, res.dma_length, res.dma_aux_address, res.dma_mem_address,
                           res.dma_direction, res.dma_start, res.audio_length,
                           res.audio_address, res.audio_send, res.mailbox_data,
                           res.mailbox_strobe, res.irq_line, res.read_data};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
